FILE: sv/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg: shared types, constants and decode functions
// Holds the table record, the controller/datapath command and status groups,
// the status codes and the AX.25 control and PID decoders.
// ----------------------------------------------------------------------------
package hst_pkg;

	localparam int TABLE_ENTRIES = 128;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int MAX_DIGIS     = 8;
	localparam int SLOT_W        = 7;

	localparam logic [55:0] CALL_MASK = 56'h1EFEFEFEFEFEFE;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NONDATA  = 3'd1;
	localparam logic [2:0] ST_SHORT    = 3'd2;
	localparam logic [2:0] ST_FILTERED = 3'd3;
	localparam logic [2:0] ST_NOCTL    = 3'd4;
	localparam logic [2:0] ST_TOOMANY  = 3'd5;

	localparam logic [3:0] K_SABM  = 4'd0;
	localparam logic [3:0] K_SABME = 4'd1;
	localparam logic [3:0] K_DISC  = 4'd2;
	localparam logic [3:0] K_UA    = 4'd3;
	localparam logic [3:0] K_DM    = 4'd4;
	localparam logic [3:0] K_RR    = 4'd5;
	localparam logic [3:0] K_RNR   = 4'd6;
	localparam logic [3:0] K_REJ   = 4'd7;
	localparam logic [3:0] K_FRMR  = 4'd8;
	localparam logic [3:0] K_I     = 4'd9;
	localparam logic [3:0] K_UI    = 4'd10;
	localparam logic [3:0] K_UNK   = 4'd11;

	typedef struct packed {
		logic [55:0] call;
		logic [3:0]  port;
		logic [31:0] total;
		logic [31:0] info;
		logic [31:0] super_cnt;
		logic [31:0] unnum;
		logic [11:0] modes;
		logic [31:0] t_first;
		logic [31:0] t_last;
	} hst_rec_t;

	typedef struct packed {
		logic nondata;
		logic extseq;
		logic addrend;
		logic toomany;
		logic havectl;
		logic havepid;
	} hst_flags_t;

	typedef struct packed {
		logic [7:0]  pos;
		logic [55:0] src;
		hst_flags_t  flags;
		logic [3:0]  digis;
		logic [7:0]  ctl_start;
		logic [7:0]  ctl;
		logic [7:0]  pid;
	} hst_parse_t;

	// Result word, last field (entry_slot) in the lowest bits.
	typedef struct packed {
		logic [4:0]  pad;
		logic [3:0]  digi_total;
		logic [31:0] last_seen;
		logic [31:0] first_seen;
		logic [11:0] mode_bits;
		logic [31:0] unnumbered_frames;
		logic [31:0] supervisory_frames;
		logic [31:0] info_frames;
		logic [31:0] total_frames;
		logic [3:0]  frame_kind;
		logic [6:0]  entry_slot;
	} hst_out_t;

	typedef struct packed {
		logic [3:0]  pad;
		logic [31:0] now_seconds;
		logic [3:0]  port_number;
		logic [7:0]  frame_byte;
	} hst_in_t;

	typedef struct packed {
		logic in_ready;
		logic eval;
		logic scan_start;
		logic pick;
		logic read;
		logic update;
		logic out_valid;
		logic out_done;
	} hst_cmd_t;

	typedef struct packed {
		logic last_in;
		logic pre_err;
		logic scan_done;
		logic out_taken;
	} hst_sts_t;

	// Control field decode: returns {two_byte_control, kind}.
	function automatic logic [4:0] classify(input logic [7:0] c, input logic ext);
		logic [7:0] t;
		logic       len2;
		logic [3:0] k;
		len2 = 1'b0;
		t    = 8'h00;
		k    = K_UNK;
		if (!c[0]) begin
			len2 = ext;
			k    = K_I;
		end else begin
			if (c[1]) begin
				t = c & 8'hEF;
			end else if (ext) begin
				t    = c;
				len2 = 1'b1;
			end else begin
				t = c & 8'h0F;
			end
			case (t)
				8'h2F:   k = K_SABM;
				8'h6F:   k = K_SABME;
				8'h43:   k = K_DISC;
				8'h63:   k = K_UA;
				8'h0F:   k = K_DM;
				8'h01:   k = K_RR;
				8'h05:   k = K_RNR;
				8'h09:   k = K_REJ;
				8'h87:   k = K_FRMR;
				8'h03:   k = K_UI;
				default: k = K_UNK;
			endcase
		end
		return {len2, k};
	endfunction

	function automatic logic [11:0] pid_mode(input logic [7:0] p, input logic [3:0] kind);
		logic [11:0] m;
		case (p)
			8'hF0:   m = 12'h001;
			8'h08:   m = 12'h002;
			8'hCD:   m = 12'h004;
			8'hCF:   m = 12'h008;
			8'hCC:   m = (kind == K_I) ? 12'h010 : 12'h020;
			8'h01:   m = 12'h040;
			8'hC3:   m = 12'h080;
			8'hCE:   m = 12'h100;
			8'hBD:   m = 12'h200;
			8'hBB:   m = 12'h400;
			default: m = 12'h800;
		endcase
		return m;
	endfunction

endpackage

FILE: sv/hst_parser.sv
// ----------------------------------------------------------------------------
// hst_parser: per-byte KISS/AX.25 header parser
// Tracks byte position, source address, digipeater walk, control and PID.
// ----------------------------------------------------------------------------
module hst_parser import hst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       first,
	input  logic [7:0] data,
	input  logic       clear,
	output hst_parse_t parse
);

	hst_parse_t cur_q;
	logic [2:0] r_q;
	logic [2:0] k_q;

	hst_parse_t nx;
	logic [2:0] r_nx;
	logic [2:0] k_nx;
	logic [7:0] d;
	logic [2:0] lane;
	logic [4:0] cls;
	logic [7:0] pid_at;
	logic [3:0] k_plus;

	always_comb begin
		nx   = first ? '0 : cur_q;
		r_nx = first ? 3'd0 : r_q;
		k_nx = first ? 3'd0 : k_q;
		d    = nx.pos - 8'd1;
		lane = 3'(d - 8'd7);
		cls  = classify(nx.ctl, nx.flags.extseq);
		pid_at = nx.ctl_start + (cls[4] ? 8'd2 : 8'd1);
		k_plus = {1'b0, k_nx} + 4'd1;
		if (nx.pos == 8'd0) begin
			if (data[3:0] != 4'd0) nx.flags.nondata = 1'b1;
		end else if (d >= 8'd7 && d <= 8'd13) begin
			nx.src[lane*8 +: 8] = data;
			if (d == 8'd13) begin
				if (!data[6]) nx.flags.extseq = 1'b1;
				if (data[0]) begin
					nx.flags.addrend = 1'b1;
					nx.ctl_start     = 8'd14;
				end
			end
		end else if (d >= 8'd14 && !nx.flags.toomany) begin
			if (!nx.flags.addrend) begin
				if (r_nx == 3'd6) begin
					if (data[0]) begin
						nx.flags.addrend = 1'b1;
						nx.digis         = k_plus;
						nx.ctl_start     = d + 8'd1;
					end else if (k_plus >= 4'(MAX_DIGIS)) begin
						nx.flags.toomany = 1'b1;
					end
					r_nx = 3'd0;
					k_nx = k_nx + 3'd1;
				end else begin
					r_nx = r_nx + 3'd1;
				end
			end else if (d == nx.ctl_start) begin
				nx.ctl           = data;
				nx.flags.havectl = 1'b1;
			end else if (nx.flags.havectl && !nx.flags.havepid && d == pid_at) begin
				nx.pid           = data;
				nx.flags.havepid = 1'b1;
			end
		end
		if (nx.pos != 8'hFF) nx.pos = nx.pos + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			r_q   <= 3'd0;
			k_q   <= 3'd0;
		end else if (clear) begin
			cur_q <= '0;
			r_q   <= 3'd0;
			k_q   <= 3'd0;
		end else if (take) begin
			cur_q <= nx;
			r_q   <= r_nx;
			k_q   <= k_nx;
		end
	end

	assign parse = cur_q;

endmodule

FILE: sv/hst_table.sv
// ----------------------------------------------------------------------------
// hst_table: station table datapath
// Holds the entry memory, the scan for match, free and oldest entries, the
// entry update and the result register.
// ----------------------------------------------------------------------------
module hst_table import hst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  hst_cmd_t     cmd,
	output hst_sts_t     sts,
	input  logic         last_take,
	input  logic [3:0]   port_in,
	input  logic [31:0]  now_in,
	input  hst_parse_t   parse,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output logic [2:0]   res_status,
	output hst_out_t     res_data
);

	localparam logic [1:0] R_FILTER_ON = 2'd0;
	localparam logic [1:0] R_EXCLUDE   = 2'd1;
	localparam logic [1:0] R_LIST      = 2'd2;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic        filter_on_q;
	logic        exclude_q;
	logic [15:0] list_q;
	logic [3:0]  port_q;
	logic [31:0] now_q;

	hst_rec_t mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] used_q;
	hst_rec_t rd_q;
	logic [IDX_W-1:0] rd_addr;

	logic             run_q;
	logic [IDX_W-1:0] idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [31:0]      best_time_q;

	logic [IDX_W-1:0] pick_q;
	logic             new_q;

	logic [2:0]  res_status_q;
	hst_out_t    res_q;

	logic        listed;
	logic [2:0]  pre_st;
	logic [2:0]  late_st;
	logic        hit;
	hst_rec_t    fresh;
	hst_rec_t    base;
	hst_rec_t    upd;
	logic [4:0]  cls;
	logic [3:0]  kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_on_q <= 1'b0;
			exclude_q   <= 1'b0;
			list_q      <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				R_FILTER_ON: filter_on_q <= cfg_data[0];
				R_EXCLUDE:   exclude_q   <= cfg_data[0];
				R_LIST:      list_q      <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (last_take) begin
			port_q <= port_in;
			now_q  <= now_in;
		end
	end

	always_comb begin
		listed = list_q[port_q];
		if (filter_on_q && (exclude_q ? listed : !listed)) pre_st = ST_FILTERED;
		else if (parse.flags.nondata) pre_st = ST_NONDATA;
		else if (parse.pos < 8'd16) pre_st = ST_SHORT;
		else pre_st = ST_OK;
		if (parse.flags.toomany) late_st = ST_TOOMANY;
		else if (!parse.flags.addrend || !parse.flags.havectl) late_st = ST_NOCTL;
		else late_st = ST_OK;
	end

	assign rd_addr = run_q ? idx_q : pick_q;

	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
		if (cmd.update && (new_q || late_st == ST_OK)) mem_q[pick_q] <= upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= run_q;
			if (cmd.scan_start) run_q <= 1'b1;
			else if (run_q && idx_q == LAST_IDX) run_q <= 1'b0;
			if (cmd.update) used_q[pick_q] <= 1'b1;
		end
	end

	assign hit = used_q[idx_s1] && (((rd_q.call ^ parse.src) & CALL_MASK) == 56'd0)
		&& rd_q.port == port_q;

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.scan_start) begin
			idx_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			best_q  <= 1'b0;
		end else begin
			if (run_q) idx_q <= idx_q + IDX_W'(1);
			if (vld_s1) begin
				if (hit && !match_q) begin
					match_q     <= 1'b1;
					match_idx_q <= idx_s1;
				end
				if (!used_q[idx_s1] && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
				if (used_q[idx_s1] && (!best_q || rd_q.t_last < best_time_q)) begin
					best_q      <= 1'b1;
					best_idx_q  <= idx_s1;
					best_time_q <= rd_q.t_last;
				end
			end
		end
		if (cmd.pick) begin
			new_q  <= !match_q;
			pick_q <= match_q ? match_idx_q : (free_q ? free_idx_q : best_idx_q);
		end
	end

	always_comb begin
		fresh      = '0;
		fresh.call = parse.src;
		fresh.port = port_q;
		base       = new_q ? fresh : rd_q;
		cls        = classify(parse.ctl, parse.flags.extseq);
		kind       = cls[3:0];
		upd        = base;
		if (late_st == ST_OK) begin
			upd.total = base.total + 32'd1;
			if (kind == K_I) upd.info = base.info + 32'd1;
			else if (kind >= K_RR && kind <= K_REJ) upd.super_cnt = base.super_cnt + 32'd1;
			else if (kind != K_UNK) upd.unnum = base.unnum + 32'd1;
			if ((kind == K_I || kind == K_UI) && parse.flags.havepid)
				upd.modes = base.modes | pid_mode(parse.pid, kind);
			if (base.t_first == 32'd0) upd.t_first = now_q;
			upd.t_last = now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			res_status_q <= pre_st;
			res_q        <= '0;
		end else if (cmd.update) begin
			res_status_q <= late_st;
			res_q        <= '0;
			if (late_st == ST_OK) begin
				res_q.entry_slot         <= SLOT_W'(pick_q);
				res_q.frame_kind         <= kind;
				res_q.total_frames       <= upd.total;
				res_q.info_frames        <= upd.info;
				res_q.supervisory_frames <= upd.super_cnt;
				res_q.unnumbered_frames  <= upd.unnum;
				res_q.mode_bits          <= upd.modes;
				res_q.first_seen         <= upd.t_first;
				res_q.last_seen          <= upd.t_last;
				res_q.digi_total         <= parse.digis;
			end
		end
	end

	assign res_status    = res_status_q;
	assign res_data      = res_q;
	assign sts.last_in   = last_take;
	assign sts.pre_err   = pre_st != ST_OK;
	assign sts.scan_done = vld_s1 && idx_s1 == LAST_IDX;
	assign sts.out_taken = 1'b0;

endmodule

FILE: sv/hst_ctrl.sv
// ----------------------------------------------------------------------------
// hst_ctrl: frame-end sequencer
// Steps through evaluation, table scan, entry pick, read, update and output.
// ----------------------------------------------------------------------------
module hst_ctrl import hst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  hst_sts_t sts,
	input  logic     out_ready,
	output hst_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_PICK = 3'd3;
	localparam logic [2:0] S_READ = 3'd4;
	localparam logic [2:0] S_UPD  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.last_in) state_nx = S_EVAL;
			end
			S_EVAL: begin
				if (sts.pre_err) begin
					cmd.eval = 1'b1;
					state_nx = S_OUT;
				end else begin
					cmd.scan_start = 1'b1;
					state_nx       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) state_nx = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_nx = S_READ;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_nx = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_nx   = S_OUT;
			end
			S_OUT: begin
				cmd.out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_done = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

endmodule

FILE: sv/heard_station_table.sv
// ----------------------------------------------------------------------------
// heard_station_table: table of stations heard on a packet radio link
// Parses KISS frames byte by byte and keeps per-station counters and times.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one frame byte per transfer, with the port number
// and the current time beside it; tuser marks the first byte of a frame and
// tlast the final byte. Ordinary bytes are taken one per cycle.
// After the final byte the block stops accepting input and works on the frame:
// the filter, type and length checks come first; a frame that passes them
// scans all TABLE_ENTRIES entries of the station memory, one read per cycle
// through its single read port, then picks, reads and rewrites one entry.
// The master stream carries one result transfer per frame: tuser holds the
// status and tdata the entry fields, all zero for a failing status.
// While the receiver stalls the result holds and no input is accepted.
// Reset empties the table at once (per-entry valid bits), clears the parser
// and the configuration registers; no clearing pass is needed.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module heard_station_table import hst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // frame_byte[7:0], port_number[11:8], now_seconds[43:12]
	input  logic         s_tuser,   // frame_first
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata,   // entry_slot, frame_kind, total_frames, info_frames,
	                                // supervisory_frames, unnumbered_frames, mode_bits,
	                                // first_seen, last_seen, digi_total
	output logic [2:0]   m_tuser,   // status
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	hst_in_t    in_w;
	hst_cmd_t   cmd;
	hst_sts_t   sts;
	hst_parse_t parse;
	hst_out_t   res;
	logic       take;

	assign in_w = s_tdata;
	// A transfer on the input side happens only while the sequencer is idle.
	assign take     = s_tvalid && cmd.in_ready;
	assign s_tready = cmd.in_ready;

	hst_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.first  (s_tuser),
		.data   (in_w.frame_byte),
		.clear  (cmd.out_done),
		.parse  (parse)
	);

	hst_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.last_take  (take && s_tlast),
		.port_in    (in_w.port_number),
		.now_in     (in_w.now_seconds),
		.parse      (parse),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_status (m_tuser),
		.res_data   (res)
	);

	hst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	assign m_tvalid = cmd.out_valid;
	assign m_tdata  = res;

`ifndef NO_ASSERTIONS
	// Input and output never transfer in the same cycle.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("input ready while result pending");

	// A failing status carries an all-zero entry.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
		else $error("error result with nonzero fields");

	// Only defined status codes are reported.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= ST_TOOMANY))
		else $error("status code out of range");

	// After a final byte is taken, the input is no longer ready.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input accepted right after frame end");
`endif

endmodule
